### hdl/bilinear_image_sampler_core_macros.svh
// Assertion macros used by the sampler controller.
`ifndef BILINEAR_IMAGE_SAMPLER_CORE_MACROS_SVH
`define BILINEAR_IMAGE_SAMPLER_CORE_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BIS_ASSERT_SAME(lbl, ante, cons, msg)
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/bis_pkg.sv
// Types, constants and codes shared by the bilinear sampler modules.
package bis_pkg;

  // Store geometry and number formats.
  localparam int MAX_BANDS   = 4;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int COORD_W  = 16;
  localparam int INT_W    = COORD_W - 1 - FRAC_BITS;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int BSEL_W   = $clog2(MAX_BANDS);
  localparam int ADDR_W   = BSEL_W + ROW_W + COL_W;
  localparam int DEPTH    = MAX_BANDS * MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W    = 7;
  localparam int BAND_W   = 3;
  localparam int WGT_W    = FRAC_BITS + 1;
  localparam int WPROD_W  = 2 * FRAC_BITS + 1;
  localparam int ACC_W    = 2 * FRAC_BITS + SAMPLE_BITS;
  localparam int VALUE_W  = 24;
  localparam int STATUS_W = 2;
  localparam int OUT_SHIFT = 2 * FRAC_BITS - 8;

  // Neighbour sequencing: four neighbours, bit 0 picks column, bit 1 row.
  localparam int NUM_NBR = 4;
  localparam int NBR_W   = 2;

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BAND = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDS  = 2'd2;

  // One input item.
  typedef struct packed {
    logic                      op;
    logic [BAND_W-1:0]         band;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
    logic [SAMPLE_BITS-1:0]    pixel_value;
  } bis_in_t;

  // One result item.
  typedef struct packed {
    logic [VALUE_W-1:0]  sample_value;
    logic [STATUS_W-1:0] status;
  } bis_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr;
    logic             latch;
    logic             issue;
    logic [NBR_W-1:0] nbr;
    logic             load;
  } bis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
  } bis_sts_t;

endpackage

### hdl/bis_datapath.sv
// Sampler datapath: configuration, image memory, weights, multipliers, accumulator.
module bis_datapath import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bis_in_t               in_item,
  input  bis_cmd_t              cmd,
  output bis_sts_t              sts,
  output bis_out_t              out_item
);

  // Configuration registers.
  logic [DIM_W-1:0]  width_r, height_r;
  logic [BAND_W-1:0] bands_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      bands_r  <= BAND_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        CFG_BANDS:  bands_r  <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Registers above the store size act as the maximum.
  logic [DIM_W-1:0]  w_lim, h_lim;
  logic [BAND_W-1:0] nb_lim;

  assign w_lim  = (width_r  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_r;
  assign h_lim  = (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;
  assign nb_lim = (bands_r  > BAND_W'(MAX_BANDS)) ? BAND_W'(MAX_BANDS) : bands_r;

  // Bounds and band checks on the incoming sample item.
  logic [INT_W-1:0]     x_int, y_int;
  logic [FRAC_BITS-1:0] x_frac, y_frac;
  logic [INT_W:0]       x_next, y_next;
  logic                 outside, bad_band;
  logic [STATUS_W-1:0]  chk_code;

  assign x_int  = in_item.x_coord[COORD_W-2:FRAC_BITS];
  assign y_int  = in_item.y_coord[COORD_W-2:FRAC_BITS];
  assign x_frac = in_item.x_coord[FRAC_BITS-1:0];
  assign y_frac = in_item.y_coord[FRAC_BITS-1:0];
  assign x_next = {1'b0, x_int} + 1'b1;
  assign y_next = {1'b0, y_int} + 1'b1;

  assign outside  = in_item.x_coord[COORD_W-1] || in_item.y_coord[COORD_W-1] ||
                    (x_int >= w_lim) || (y_int >= h_lim);
  assign bad_band = (in_item.band == '0) || (in_item.band > nb_lim);
  assign chk_code = outside ? ST_OUTSIDE : (bad_band ? ST_BAD_BAND : ST_OK);
  assign sts.err  = outside || bad_band;

  // Sample context captured at accept.
  logic [COL_W-1:0]     x1_r;
  logic [ROW_W-1:0]     y1_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic                 xedge_r, yedge_r;
  logic [BSEL_W-1:0]    bsel_r;
  logic [STATUS_W-1:0]  code_r;
  logic [BAND_W-1:0]    band_m1;

  assign band_m1 = in_item.band - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      x1_r    <= x_int[COL_W-1:0];
      y1_r    <= y_int[ROW_W-1:0];
      fx_r    <= x_frac;
      fy_r    <= y_frac;
      xedge_r <= (x_next >= {1'b0, w_lim});
      yedge_r <= (y_next >= {1'b0, h_lim});
      bsel_r  <= band_m1[BSEL_W-1:0];
      code_r  <= chk_code;
    end
  end

  // Write address and range check; the row and column fields always fit.
  logic             wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
  logic [COL_W-1:0] rd_col;
  logic [ROW_W-1:0] rd_row;

  assign wr_ok   = cmd.wr && (in_item.band != '0) && (in_item.band <= BAND_W'(MAX_BANDS));
  assign wr_addr = {band_m1[BSEL_W-1:0], in_item.pixel_row, in_item.pixel_col};
  assign rd_col  = x1_r + COL_W'(cmd.nbr[0]);
  assign rd_row  = y1_r + ROW_W'(cmd.nbr[1]);
  assign rd_addr = {bsel_r, rd_row, rd_col};
  assign mem_addr = cmd.wr ? wr_addr : rd_addr;

  // Single-port image memory with registered read data.
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[mem_addr] <= in_item.pixel_value;
    end
    if (cmd.issue) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Axis weights for the neighbour being read; edge neighbours get none.
  localparam logic [WGT_W-1:0] ONE_W = WGT_W'(1 << FRAC_BITS);
  logic [WGT_W-1:0]     wx, wy;
  logic [2*WGT_W-1:0]   wprod_full;
  logic                 skip;

  always_comb begin
    if (!cmd.nbr[0]) begin
      wx = xedge_r ? ONE_W : ONE_W - {1'b0, fx_r};
    end else begin
      wx = xedge_r ? '0 : {1'b0, fx_r};
    end
    if (!cmd.nbr[1]) begin
      wy = yedge_r ? ONE_W : ONE_W - {1'b0, fy_r};
    end else begin
      wy = yedge_r ? '0 : {1'b0, fy_r};
    end
  end

  assign wprod_full = wx * wy;
  assign skip = (cmd.nbr[0] && xedge_r) || (cmd.nbr[1] && yedge_r);

  // Stage one: weight product alongside the memory read.
  logic [WPROD_W-1:0] wprod_r;
  logic               skip_r, vld1_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      wprod_r <= wprod_full[WPROD_W-1:0];
      skip_r  <= skip;
    end
  end

  // Stage two: weight times pixel; skipped neighbours contribute zero.
  logic [SAMPLE_BITS-1:0]        pix;
  logic [WPROD_W+SAMPLE_BITS-1:0] prod_full;
  logic [ACC_W-1:0]              prod_r, acc_r;
  logic                          vld2_r;

  assign pix       = skip_r ? '0 : rdata_r;
  assign prod_full = wprod_r * pix;

  always_ff @(posedge clk) begin
    if (vld1_r) begin
      prod_r <= prod_full[ACC_W-1:0];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= cmd.issue;
      vld2_r <= vld1_r;
    end
  end

  // Stage three: accumulate, cleared when a sample item is taken.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc_r <= '0;
    end else if (vld2_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  // Result payload register.
  bis_out_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.sample_value <= (code_r == ST_OK) ? acc_r[OUT_SHIFT +: VALUE_W] : '0;
      out_r.status       <= code_r;
    end
  end

  assign out_item = out_r;

endmodule

### hdl/bis_ctrl.sv
// Sampler controller: accepts items and sequences the four neighbour reads.
module bis_ctrl import bis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  bis_sts_t sts,
  output bis_cmd_t cmd
);

  `include "bilinear_image_sampler_core_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [NBR_W-1:0] NBR_LAST   = NBR_W'(NUM_NBR - 1);
  localparam logic [NBR_W-1:0] DRAIN_LAST = NBR_W'(1);

  logic [1:0]       state_r, state_nxt;
  logic [NBR_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.nbr   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_SAMPLE) begin
            cmd.latch = 1'b1;
            cnt_nxt   = '0;
            state_nxt = sts.err ? S_FIN : S_READ;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == NBR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DRAIN_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A taken sample item goes either to the reads or straight to its result.
  `BIS_ASSERT_NEXT(a_sample_start, in_valid && !in_stall && in_op == OP_SAMPLE, state_r == S_READ || state_r == S_FIN, "sample item did not start")
  // A result appears only after the finishing state.
  `BIS_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r) == S_FIN, "result without finish")
  // All four neighbours are read before the pipeline drains.
  `BIS_ASSERT_NEXT(a_read_run, state_r == S_READ && cnt_r != NBR_LAST, state_r == S_READ, "neighbour reads cut short")
  // A pending result is never overwritten while stalled.
  `BIS_ASSERT_SAME(a_no_clobber, out_valid_r && out_stall, !cmd.load, "result overwritten")

endmodule

### hdl/bilinear_image_sampler_core.sv
// Top level of the bilinear image sampler.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    bis_in_t  (op, band, coords, pixel)
//   out_     output     out_valid / out_stall  bis_out_t (sample_value, status)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel write item is taken while the controller stays idle and produces no result.
// A sample item passes through the accept, four reads of the single-port image memory
// (one neighbour a cycle), a drain of the multiply and accumulate stages, and a final
// state that loads the result. Items failing the bounds or band check go from the
// accept straight to that final state. A stalled result holds in the output register;
// the next item may be accepted meanwhile, and a sample that finishes while it is
// still held waits in its final state. Reset clears control and loads the default
// configuration; the image memory is not cleared.
module bilinear_image_sampler_core import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bis_in_t               in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bis_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bis_cmd_t cmd;
  bis_sts_t sts;

  // Configuration is taken at any time.
  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bis_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
